[rtl/apn_pkg.sv]
`timescale 1ns / 1ps
package apn_pkg;

	localparam int TARGET_BITS = 16;
	localparam int GAIN_BITS   = 32;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_MEASURE = 2'd1,
		OP_SCALE   = 2'd2
	} op_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_FETCH  = 4'd0;
	localparam step_t ST_DECODE = 4'd1;
	localparam step_t ST_GCHK   = 4'd2;
	localparam step_t ST_DIV    = 4'd3;
	localparam step_t ST_GSET   = 4'd4;
	localparam step_t ST_MLO    = 4'd5;
	localparam step_t ST_MHI    = 4'd6;
	localparam step_t ST_ACC    = 4'd7;
	localparam step_t ST_EMIT   = 4'd8;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_PEAK,
		ACT_DIV_INIT,
		ACT_DIV_STEP,
		ACT_GAIN_SET,
		ACT_MUL_LO,
		ACT_MUL_HI,
		ACT_ACC,
		ACT_EMIT
	} act_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_WAIT_IN,
		C_IF_NSCALE,
		C_IF_READY,
		C_IF_DIV_MORE,
		C_WAIT_OUT
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic init;
		logic step;
	} div_ctrl_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			ST_FETCH:  w = '{act: ACT_LOAD,     cond: C_WAIT_IN,     target: ST_FETCH};
			ST_DECODE: w = '{act: ACT_PEAK,     cond: C_IF_NSCALE,   target: ST_EMIT};
			ST_GCHK:   w = '{act: ACT_DIV_INIT, cond: C_IF_READY,    target: ST_MLO};
			ST_DIV:    w = '{act: ACT_DIV_STEP, cond: C_IF_DIV_MORE, target: ST_DIV};
			ST_GSET:   w = '{act: ACT_GAIN_SET, cond: C_NEXT,        target: ST_FETCH};
			ST_MLO:    w = '{act: ACT_MUL_LO,   cond: C_NEXT,        target: ST_FETCH};
			ST_MHI:    w = '{act: ACT_MUL_HI,   cond: C_NEXT,        target: ST_FETCH};
			ST_ACC:    w = '{act: ACT_ACC,      cond: C_NEXT,        target: ST_FETCH};
			ST_EMIT:   w = '{act: ACT_EMIT,     cond: C_WAIT_OUT,    target: ST_FETCH};
			default:   w = '{act: ACT_NONE,     cond: C_IF_READY,    target: ST_FETCH};
		endcase
		return w;
	endfunction

endpackage

[rtl/apn_if.sv]
`timescale 1ns / 1ps
interface apn_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output op, output sample, input ready);
	modport sink(input valid, input op, input sample, output ready);
endinterface

interface apn_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] scaled_sample;
	logic [SAMPLE_BITS-1:0]        peak_level;
	logic                          clipped;

	modport source(output valid, output scaled_sample, output peak_level, output clipped,
		input ready);
	modport sink(input valid, input scaled_sample, input peak_level, input clipped,
		output ready);
endinterface

[rtl/audio_peak_normalizer.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Transaction
// samples   in   op[1:0], sample[SAMPLE_BITS-1:0]         valid & ready
// results   out  scaled_sample, peak_level, clipped       valid & ready
// cfg       in   cfg_wdata[15:0] (target_level)           cfg_we
//
// Clear, measure and unused ops go from decode straight to emit; a scale item runs the
// multiply steps, first recomputing the gain after reset, a clear or a measure (restoring divider,
// one quotient bit per cycle). Steps come from a microcode ROM driven by a step counter.
// Reset clears the step counter, result valid, peak, gain and sets target_level to 32768.
// Input is taken only at the fetch step; the emit step holds while the result is unread.
module audio_peak_normalizer #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	apn_in_if.sink                               samples,
	apn_out_if.source                            results,
	input  logic                                 cfg_we,
	input  logic [apn_pkg::TARGET_BITS-1:0]      cfg_wdata
);
	import apn_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int DW = TARGET_BITS + SB;
	localparam int PW = SB + 17;
	localparam int AW = SB + 34;
	localparam int YW = AW - 16;
	localparam logic [AW-1:0] ROUND = AW'(1) << 15;

	step_t                  step_q;
	step_t                  step_nxt;
	uword_t                 uw;
	logic [1:0]             op_q;
	logic [SB-1:0]          sample_q;
	logic [TARGET_BITS-1:0] target_q;
	logic [SB-1:0]          peak_q;
	logic [GAIN_BITS-1:0]   gain_q;
	logic                   gain_ready_q;
	logic signed [PW-1:0]   prod_q;
	logic [AW-1:0]          acc_q;
	logic                   out_valid_q;
	logic [SB-1:0]          scaled_q;
	logic [SB-1:0]          peak_out_q;
	logic                   clip_q;

	logic                   in_fire;
	logic                   out_free;
	logic                   div_last;
	logic [DW-1:0]          quot;
	logic [DW+31:0]         quot_x;
	logic [GAIN_BITS-1:0]   gain_sat;
	div_ctrl_t              div_ctrl;
	logic                   do_load;
	logic                   do_peak;
	logic                   do_gain;
	logic                   do_mul_lo;
	logic                   do_mul_hi;
	logic                   do_acc;
	logic                   do_emit;
	logic [SB-1:0]          mag;
	logic [16:0]            mul_b;
	logic signed [PW-1:0]   mul_p;
	logic [YW-1:0]          y;
	logic [YW-SB:0]         y_top;
	logic                   ovf;
	logic [SB-1:0]          y_sat;
	logic                   is_scale;

	assign uw       = ucode(step_q);
	assign in_fire  = samples.valid && samples.ready;
	assign out_free = !out_valid_q || results.ready;
	assign is_scale = op_q == OP_SCALE;

	assign samples.ready         = uw.cond == C_WAIT_IN;
	assign results.valid         = out_valid_q;
	assign results.scaled_sample = scaled_q;
	assign results.peak_level    = peak_out_q;
	assign results.clipped       = clip_q;

	apn_div #(
		.SAMPLE_BITS(SB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.target   (target_q),
		.divisor  (peak_q),
		.quotient (quot),
		.last     (div_last)
	);

	always_comb begin
		unique case (uw.cond)
			C_NEXT:        step_nxt = step_q + step_t'(1);
			C_WAIT_IN:     step_nxt = in_fire ? step_q + step_t'(1) : step_q;
			C_IF_NSCALE:   step_nxt = !is_scale ? uw.target : step_q + step_t'(1);
			C_IF_READY:    step_nxt = gain_ready_q ? uw.target : step_q + step_t'(1);
			C_IF_DIV_MORE: step_nxt = !div_last ? uw.target : step_q + step_t'(1);
			C_WAIT_OUT:    step_nxt = out_free ? uw.target : step_q;
			default:       step_nxt = ST_FETCH;
		endcase
	end

	always_comb begin
		div_ctrl  = '0;
		do_load   = 1'b0;
		do_peak   = 1'b0;
		do_gain   = 1'b0;
		do_mul_lo = 1'b0;
		do_mul_hi = 1'b0;
		do_acc    = 1'b0;
		do_emit   = 1'b0;
		unique case (uw.act)
			ACT_LOAD:     do_load = in_fire;
			ACT_PEAK:     do_peak = 1'b1;
			ACT_DIV_INIT: div_ctrl.init = 1'b1;
			ACT_DIV_STEP: div_ctrl.step = 1'b1;
			ACT_GAIN_SET: do_gain = 1'b1;
			ACT_MUL_LO:   do_mul_lo = 1'b1;
			ACT_MUL_HI:   do_mul_hi = 1'b1;
			ACT_ACC:      do_acc = 1'b1;
			ACT_EMIT:     do_emit = out_free;
			default:      ;
		endcase
	end

	assign mag      = sample_q[SB-1] ? (~sample_q + SB'(1)) : sample_q;
	assign quot_x   = {32'b0, quot};
	assign gain_sat = (quot_x[DW+31:32] != '0) ? {GAIN_BITS{1'b1}} : quot_x[31:0];
	assign mul_b    = do_mul_lo ? {1'b0, gain_q[15:0]} : {1'b0, gain_q[31:16]};
	assign mul_p    = $signed(sample_q) * $signed(mul_b);
	assign y        = acc_q[AW-1:16];
	assign y_top    = y[YW-1:SB-1];
	assign ovf      = (y_top != '0) && (y_top != '1);
	assign y_sat    = y[YW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_FETCH;
			target_q     <= TARGET_BITS'(32768);
			peak_q       <= '0;
			gain_q       <= '0;
			gain_ready_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (do_peak) begin
				case (op_q)
					OP_CLEAR: begin
						peak_q       <= '0;
						gain_ready_q <= 1'b0;
					end
					OP_MEASURE: begin
						if (mag > peak_q) begin
							peak_q <= mag;
						end
						gain_ready_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (do_gain) begin
				gain_q       <= (peak_q == '0) ? '0 : gain_sat;
				gain_ready_q <= 1'b1;
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			op_q     <= samples.op;
			sample_q <= samples.sample;
		end
		if (do_mul_lo || do_mul_hi) begin
			prod_q <= mul_p;
		end
		if (do_mul_hi) begin
			acc_q <= {{(AW-PW){prod_q[PW-1]}}, prod_q} + ROUND;
		end else if (do_acc) begin
			acc_q <= acc_q + {{(AW-PW-16){prod_q[PW-1]}}, prod_q, 16'b0};
		end
		if (do_emit) begin
			scaled_q   <= !is_scale ? '0 : (ovf ? y_sat : y[SB-1:0]);
			clip_q     <= is_scale && ovf;
			peak_out_q <= peak_q;
		end
	end

endmodule

[rtl/apn_div.sv]
`timescale 1ns / 1ps
module apn_div #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  apn_pkg::div_ctrl_t                             ctrl,
	input  logic [apn_pkg::TARGET_BITS-1:0]                target,
	input  logic [SAMPLE_BITS-1:0]                         divisor,
	output logic [apn_pkg::TARGET_BITS+SAMPLE_BITS-1:0]    quotient,
	output logic                                           last
);
	import apn_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int DW = TARGET_BITS + SB;
	localparam int CW = $clog2(DW);

	logic [DW-1:0] sh_q;
	logic [SB-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [SB:0]   trial;
	logic [SB:0]   diff;
	logic          ge;

	assign trial    = {rem_q, sh_q[DW-1]};
	assign diff     = trial - {1'b0, divisor};
	assign ge       = trial >= {1'b0, divisor};
	assign quotient = sh_q;
	assign last     = cnt_q == CW'(DW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.init) begin
			cnt_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			sh_q  <= {target, {SB{1'b0}}};
			rem_q <= '0;
		end else if (ctrl.step) begin
			sh_q  <= {sh_q[DW-2:0], ge};
			rem_q <= ge ? diff[SB-1:0] : trial[SB-1:0];
		end
	end

endmodule

[rtl/apn_checker.sv]
`timescale 1ns / 1ps
module apn_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] scaled_sample,
	input logic [SAMPLE_BITS-1:0] peak_level,
	input logic                   clipped
);
	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scaled_sample)
			&& $stable(peak_level) && $stable(clipped))
		else $error("stalled result changed");

	a_clip_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> scaled_sample == SMAX || scaled_sample == SMIN)
		else $error("clipped result not at a rail");

	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_level <= SMIN)
		else $error("peak level above full scale");

endmodule

bind audio_peak_normalizer apn_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_apn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (samples.valid),
	.in_ready      (samples.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.scaled_sample (results.scaled_sample),
	.peak_level    (results.peak_level),
	.clipped       (results.clipped)
);
